### rtl/core/bfdh_pkg.sv
`timescale 1ns / 1ps
// Package for the Bloom filter with double hashing: operation codes, hash constants,
// the probe-stage control word and the FNV-1a hash step. No dependencies.
package bfdh_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_ADD   = 2'd0;
    localparam op_t OP_QUERY = 2'd1;
    localparam op_t OP_WRITE = 2'd2;
    localparam op_t OP_CLEAR = 2'd3;

    localparam int KEY_W   = 8;
    localparam int INDEX_W = 6;

    localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;
    localparam int          ROT_LEFT   = 17;

    // Control part of the word held in the probe register
    typedef struct packed {
        logic               valid;
        op_t                op;
        logic               last;
        logic [INDEX_W-1:0] index;
        logic [KEY_W-1:0]   fbyte;
    } probe_ctl_t;

    // One FNV-1a step; the prime 0x100000001B3 as shift-and-add
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [KEY_W-1:0] b);
        logic [63:0] x;
        x = h ^ {{(64-KEY_W){1'b0}}, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

    function automatic logic [63:0] rotl_mix(input logic [63:0] v);
        return {v[63-ROT_LEFT:0], v[63:64-ROT_LEFT]};
    endfunction

endpackage

### rtl/core/bfdh_item_if.sv
`timescale 1ns / 1ps
// Input channel of the Bloom filter: valid/ready plus one key or filter command word.
// Depends on bfdh_pkg.
interface bfdh_item_if;
    logic                                    valid;
    logic                                    ready;
    bfdh_pkg::op_t                           operation;
    logic [bfdh_pkg::KEY_W-1:0]              key_byte;
    logic                                    byte_valid;
    logic                                    last_byte;
    logic [bfdh_pkg::INDEX_W-1:0]            filter_index;
    logic [bfdh_pkg::KEY_W-1:0]              filter_byte;

    modport source
    (
        output valid, operation, key_byte, byte_valid, last_byte, filter_index, filter_byte,
        input  ready
    );
    modport sink
    (
        input  valid, operation, key_byte, byte_valid, last_byte, filter_index, filter_byte,
        output ready
    );
endinterface

### rtl/core/bfdh_result_if.sv
`timescale 1ns / 1ps
// Result channel of the Bloom filter: valid/ready plus the outcome of one finished key.
// No dependencies.
interface bfdh_result_if;
    logic valid;
    logic ready;
    logic might_contain;
    logic filter_was_empty;
    logic was_query;

    modport source
    (
        output valid, might_contain, filter_was_empty, was_query,
        input  ready
    );
    modport sink
    (
        input  valid, might_contain, filter_was_empty, was_query,
        output ready
    );
endinterface

### rtl/core/bfdh_hash.sv
`timescale 1ns / 1ps
// Input register, running FNV-1a / mixed hashes and the probe register.
// Depends on bfdh_pkg and bfdh_item_if.
module bfdh_hash #(
    parameter int POS_W = 9
) (
    input  logic                    clk,
    input  logic                    rst_n,
    bfdh_item_if.sink               item,
    input  logic                    probe_take,
    output bfdh_pkg::probe_ctl_t    probe_ctl,
    output logic [POS_W-1:0]        probe_h1,
    output logic [POS_W-1:0]        probe_h2
);

    logic                             s1_valid_reg;
    bfdh_pkg::op_t                    s1_op_reg;
    logic [bfdh_pkg::KEY_W-1:0]       s1_key_reg;
    logic                             s1_bvalid_reg;
    logic                             s1_last_reg;
    logic [bfdh_pkg::INDEX_W-1:0]     s1_index_reg;
    logic [bfdh_pkg::KEY_W-1:0]       s1_fbyte_reg;

    logic [63:0]                      fnv_reg;
    logic [63:0]                      mix_reg;
    logic [63:0]                      fnv_next;
    logic [63:0]                      mix_next;
    logic [63:0]                      fnv_abs;
    logic [63:0]                      mix_abs;

    bfdh_pkg::probe_ctl_t             p_ctl_reg;
    logic                             p_valid_reg;
    logic [POS_W-1:0]                 p_h1_reg;
    logic [POS_W-1:0]                 p_h2_reg;

    logic                             p_ready;
    logic                             s1_fire;
    logic                             s1_is_key;

    assign p_ready    = !p_valid_reg || probe_take;
    assign s1_fire    = s1_valid_reg && p_ready;
    assign item.ready = !s1_valid_reg || p_ready;
    assign s1_is_key  = (s1_op_reg == bfdh_pkg::OP_ADD) || (s1_op_reg == bfdh_pkg::OP_QUERY);

    always_comb
    begin
        fnv_abs  = fnv_reg;
        mix_abs  = mix_reg;
        if (s1_bvalid_reg)
        begin
            fnv_abs = bfdh_pkg::fnv_step(fnv_reg, s1_key_reg);
            mix_abs = bfdh_pkg::rotl_mix(bfdh_pkg::fnv_step(mix_reg, s1_key_reg));
        end
        fnv_next = fnv_reg;
        mix_next = mix_reg;
        if (s1_fire && s1_is_key)
        begin
            // back to the basis once the key is finished
            fnv_next = s1_last_reg ? bfdh_pkg::HASH_BASIS : fnv_abs;
            mix_next = s1_last_reg ? bfdh_pkg::HASH_BASIS : mix_abs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            fnv_reg      <= bfdh_pkg::HASH_BASIS;
            mix_reg      <= bfdh_pkg::HASH_BASIS;
        end
        else
        begin
            fnv_reg <= fnv_next;
            mix_reg <= mix_next;
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (p_ready)
            begin
                p_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_op_reg     <= item.operation;
            s1_key_reg    <= item.key_byte;
            s1_bvalid_reg <= item.byte_valid;
            s1_last_reg   <= item.last_byte;
            s1_index_reg  <= item.filter_index;
            s1_fbyte_reg  <= item.filter_byte;
        end
        if (s1_fire)
        begin
            p_ctl_reg.valid <= 1'b1;
            p_ctl_reg.op    <= s1_op_reg;
            p_ctl_reg.last  <= s1_last_reg;
            p_ctl_reg.index <= s1_index_reg;
            p_ctl_reg.fbyte <= s1_fbyte_reg;
            p_h1_reg        <= fnv_abs[POS_W-1:0];
            p_h2_reg        <= {mix_abs[POS_W-1:1], 1'b1};
        end
    end

    // the reset-held valid bit rides on the control word
    always_comb
    begin
        probe_ctl       = p_ctl_reg;
        probe_ctl.valid = p_valid_reg;
    end

    assign probe_h1  = p_h1_reg;
    assign probe_h2  = p_h2_reg;

endmodule

### rtl/core/bfdh_probe.sv
`timescale 1ns / 1ps
// Filter bit store, probe set/test, whole-filter clear, byte load and the result register.
// Depends on bfdh_pkg and bfdh_result_if.
module bfdh_probe #(
    parameter int FILTER_BYTES = 64,
    parameter int POS_W        = 9
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bfdh_pkg::probe_ctl_t    probe_ctl,
    input  logic [POS_W-1:0]        probe_h1,
    input  logic [POS_W-1:0]        probe_h2,
    output logic                    probe_take,
    bfdh_result_if.source           result
);

    localparam int FILTER_BITS = FILTER_BYTES * 8;
    localparam int IDX_W       = $clog2(FILTER_BYTES);
    localparam int PROBES      = 8;

    logic [FILTER_BITS-1:0]            filter_reg;
    logic [FILTER_BITS-1:0]            filter_next;
    logic [FILTER_BYTES-1:0]           nz_reg;
    logic [FILTER_BYTES-1:0]           nz_next;
    logic                              out_valid_reg;
    logic                              might_reg;
    logic                              empty_reg;
    logic                              query_reg;

    logic [POS_W-1:0]                  pos [PROBES];
    logic [FILTER_BITS-1:0]            probe_mask;
    logic                              all_hit;
    logic [IDX_W+bfdh_pkg::INDEX_W-1:0] idx_wide;
    logic [IDX_W-1:0]                  write_idx;
    logic                              emits;
    logic                              out_free;
    logic                              fire;
    logic                              empty;

    assign emits      = probe_ctl.valid && probe_ctl.last
                        && ((probe_ctl.op == bfdh_pkg::OP_ADD)
                        || (probe_ctl.op == bfdh_pkg::OP_QUERY));
    assign out_free   = !out_valid_reg || result.ready;
    assign probe_take = !emits || out_free;
    assign fire       = probe_ctl.valid && probe_take;
    assign empty      = ~|nz_reg;

    // wrap the byte index modulo 2**IDX_W, which is the filter size when FILTER_BYTES is a power of two
    assign idx_wide   = (IDX_W + bfdh_pkg::INDEX_W)'(probe_ctl.index);
    assign write_idx  = idx_wide[IDX_W-1:0];

    always_comb
    begin
        pos[0] = probe_h1;
        for (int i = 1; i < PROBES; i++)
        begin
            pos[i] = pos[i-1] + probe_h2;
        end
        probe_mask = '0;
        all_hit    = 1'b1;
        for (int i = 0; i < PROBES; i++)
        begin
            probe_mask[pos[i]] = 1'b1;
            all_hit            = all_hit & filter_reg[pos[i]];
        end
    end

    always_comb
    begin
        filter_next = filter_reg;
        if (fire)
        begin
            unique case (probe_ctl.op)
                bfdh_pkg::OP_ADD:
                begin
                    if (probe_ctl.last)
                    begin
                        filter_next = filter_reg | probe_mask;
                    end
                end
                bfdh_pkg::OP_QUERY:
                begin
                    filter_next = filter_reg;
                end
                bfdh_pkg::OP_WRITE:
                begin
                    filter_next[{write_idx, 3'b000} +: 8] = probe_ctl.fbyte;
                end
                bfdh_pkg::OP_CLEAR:
                begin
                    filter_next = '0;
                end
                default:
                begin
                    filter_next = filter_reg;
                end
            endcase
        end
        for (int b = 0; b < FILTER_BYTES; b++)
        begin
            nz_next[b] = |filter_next[b*8 +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg    <= '0;
            nz_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            filter_reg <= filter_next;
            nz_reg     <= nz_next;
            if (out_free)
            begin
                out_valid_reg <= fire && emits;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && fire && emits)
        begin
            might_reg <= (probe_ctl.op == bfdh_pkg::OP_ADD) || empty || all_hit;
            empty_reg <= empty;
            query_reg <= (probe_ctl.op == bfdh_pkg::OP_QUERY);
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.might_contain    = might_reg;
    assign result.filter_was_empty = empty_reg;
    assign result.was_query        = query_reg;

endmodule

### rtl/core/bloom_filter_double_hash.sv
`timescale 1ns / 1ps
// Bloom filter with FNV-1a double hashing, top level.
// Channels: item (sink) carries one word per key byte or filter command; result (source)
// carries one word per finished key. A word moves when valid and ready are both high.
// Operations: add key byte, query key byte, write one filter byte, clear the filter.
// Add and query bytes feed two running 64-bit hashes (FNV-1a, and FNV-1a then rotate
// left by 17). The word marked last_byte probes 8 positions h1 + i*(h2|1) in the filter:
// an add sets them, a query tests them, and one result word goes out.
// Order: a key byte advances the hashes as it moves from the input register to the probe
// register; a word leaving the probe register writes the filter and the result register.
// Throughput: one word per cycle while result is not held off. The clock is set by the
// shift-and-add hash step in the first stage and the 8-probe set/test in the second.
// Reset: the filter clears, both hashes return to the offset basis, the pipeline empties
// and the input is ready once reset is released.
// Stall: while result is held off, the result register keeps its word; non-result words
// still flow, a word that would produce a result waits in the probe register and the
// input keeps accepting until the input register also fills.
module bloom_filter_double_hash #(
    parameter int FILTER_BYTES = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    bfdh_item_if.sink       item,
    bfdh_result_if.source   result
);

    // probe positions address single bits of the filter
    localparam int POS_W = $clog2(FILTER_BYTES * 8);

    bfdh_pkg::probe_ctl_t   probe_ctl;
    logic [POS_W-1:0]       probe_h1;
    logic [POS_W-1:0]       probe_h2;
    logic                   probe_take;

    // hash stage: hold the input word, advance the hashes, load the probe register
    bfdh_hash #(
        .POS_W (POS_W)
    ) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .probe_take (probe_take),
        .probe_ctl  (probe_ctl),
        .probe_h1   (probe_h1),
        .probe_h2   (probe_h2)
    );

    // probe stage: apply the word to the filter and register the result
    bfdh_probe #(
        .FILTER_BYTES (FILTER_BYTES),
        .POS_W        (POS_W)
    ) u_probe (
        .clk        (clk),
        .rst_n      (rst_n),
        .probe_ctl  (probe_ctl),
        .probe_h1   (probe_h1),
        .probe_h2   (probe_h2),
        .probe_take (probe_take),
        .result     (result)
    );

endmodule

### rtl/core/bfdh_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the Bloom filter result channel, and the bind to the top level.
// Depends on bloom_filter_double_hash and bfdh_result_if.
module bfdh_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic might_contain,
    input logic filter_was_empty,
    input logic was_query
);

    // no result word while reset is applied
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // an add always reports a possible hit
    a_add_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !was_query) |-> might_contain)
        else $error("add result without might_contain");

    // an empty filter reports a possible hit
    a_empty_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && filter_was_empty) |-> might_contain)
        else $error("empty filter result without might_contain");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        ($stable(might_contain) && $stable(filter_was_empty) && $stable(was_query)))
        else $error("result changed while stalled");

endmodule

bind bloom_filter_double_hash bfdh_checker u_bfdh_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .might_contain    (result.might_contain),
    .filter_was_empty (result.filter_was_empty),
    .was_query        (result.was_query)
);
